// ----- sv/eapa_pkg.sv -----
// ----------------------------------------------------------------------------
// eapa_pkg
// shared constants and types for the affine point adder over gf(p)
// ----------------------------------------------------------------------------
`default_nettype none
package eapa_pkg;
	localparam int unsigned COORD_BITS_DEF = 64;
	localparam logic [63:0] PRIME_RST = 64'hFFFF_FFFF_FFFF_FFC5;
	localparam logic [63:0] COEFF_A_RST = 64'd0;
	localparam int unsigned CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRIME = 1'b0,
		CFG_COEFF_A = 1'b1
	} cfg_idx_t;

	// operation codes for the shared bit-serial arithmetic unit
	typedef enum logic [1:0] {
		OP_RED = 2'd0,
		OP_MUL = 2'd1,
		OP_INV = 2'd2
	} op_t;
endpackage
`default_nettype wire

// ----- sv/eapa_if.sv -----
// ----------------------------------------------------------------------------
// eapa_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
`default_nettype none
interface eapa_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/eapa_alu.sv -----
// ----------------------------------------------------------------------------
// eapa_alu
// bit-serial modular unit: reduction, multiplication and inversion
// ----------------------------------------------------------------------------
`default_nettype none
module eapa_alu
	import eapa_pkg::*;
#(
	parameter int unsigned W = COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire op_t op,
	input wire logic [W-1:0] opa,
	input wire logic [W-1:0] opb,
	input wire logic [W-1:0] m,
	output logic done,
	output logic [W-1:0] res
);
	// reduction: restoring shift-subtract, one bit a cycle
	// multiplication: msb-first double and add, one bit a cycle
	// inversion: binary extended gcd, one step a cycle
	typedef enum logic [1:0] {ST_IDLE, ST_RED, ST_MUL, ST_INV} st_t;
	localparam int unsigned CW = $clog2(4*W+5);

	st_t st_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] a_q, b_q, acc_q;
	logic [W:0] u_q, v_q;
	logic [W-1:0] x1_q, x2_q;

	function automatic logic [W-1:0] addm(logic [W-1:0] x, logic [W-1:0] y,
		logic [W-1:0] md);
		logic [W-1:0] room;
		room = md - y;
		return (x >= room) ? x - room : x + y;
	endfunction
	function automatic logic [W-1:0] subm(logic [W-1:0] x, logic [W-1:0] y,
		logic [W-1:0] md);
		return (x >= y) ? x - y : md - (y - x);
	endfunction
	function automatic logic [W-1:0] halfm(logic [W-1:0] x, logic [W-1:0] md);
		logic [W:0] s;
		s = x[0] ? ({1'b0, x} + {1'b0, md}) : {1'b0, x};
		return s[W:1];
	endfunction

	logic [W:0] rem_sh;
	logic [W-1:0] dbl, dbl_add;
	always_comb begin
		rem_sh = {acc_q, a_q[W-1]};
		dbl = addm(acc_q, acc_q, m);
		dbl_add = b_q[W-1] ? addm(dbl, a_q, m) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						// gcd steps: at most two per bit of u and v together
						cnt_q <= (op == OP_INV) ? CW'(4*W+4) : CW'(W);
						acc_q <= '0;
						a_q <= opa;
						b_q <= opb;
						u_q <= {1'b0, opa};
						v_q <= {1'b0, m};
						x1_q <= (m == W'(1)) ? '0 : W'(1);
						x2_q <= '0;
						unique case (op)
							OP_RED: st_q <= ST_RED;
							OP_MUL: st_q <= ST_MUL;
							OP_INV: st_q <= ST_INV;
							default: st_q <= ST_IDLE;
						endcase
					end
				end
				ST_RED: begin
					a_q <= a_q << 1;
					acc_q <= (rem_sh >= {1'b0, m}) ? W'(rem_sh - {1'b0, m})
						: rem_sh[W-1:0];
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						st_q <= ST_IDLE;
						done <= 1'b1;
						res <= (rem_sh >= {1'b0, m}) ? W'(rem_sh - {1'b0, m})
							: rem_sh[W-1:0];
					end
				end
				ST_MUL: begin
					b_q <= b_q << 1;
					acc_q <= dbl_add;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						st_q <= ST_IDLE;
						done <= 1'b1;
						res <= dbl_add;
					end
				end
				ST_INV: begin
					// invariants: x1*a = u, x2*a = v (mod m), m odd
					cnt_q <= cnt_q - 1'b1;
					if (u_q == '0 || v_q == '0 || u_q == (W+1)'(1) ||
							v_q == (W+1)'(1) || cnt_q == CW'(0)) begin
						st_q <= ST_IDLE;
						done <= 1'b1;
						res <= (u_q == (W+1)'(1)) ? x1_q
							: ((v_q == (W+1)'(1)) ? x2_q : '0);
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
						x1_q <= halfm(x1_q, m);
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
						x2_q <= halfm(x2_q, m);
					end else if (u_q >= v_q) begin
						u_q <= u_q - v_q;
						x1_q <= subm(x1_q, x2_q, m);
					end else begin
						v_q <= v_q - u_q;
						x2_q <= subm(x2_q, x1_q, m);
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start)
			assert (op == OP_RED || op == OP_MUL || op == OP_INV)
				else $error("bad op");
	end
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> st_q == ST_IDLE) else $error("done outside idle");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |=> !(done && $past(st_q) == ST_IDLE))
		else $error("done without work");
	a_mul_len: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MUL && cnt_q == CW'(1)) |=> done) else $error("mul length");
endmodule
`default_nettype wire

// ----- sv/ecc_affine_point_add_gfp.sv -----
// ----------------------------------------------------------------------------
// ecc_affine_point_add_gfp
// affine point addition on y^2 = x^3 + ax + b over gf(p)
// ----------------------------------------------------------------------------
// channel   dir  payload
// pin       in   first_x/y/at_infinity, second_x/y/at_infinity
// pout      out  sum_x, sum_y, sum_at_infinity
// cfg       in   cfg_we, cfg_idx, cfg_data (p, a)
//
// one item at a time through one shared bit-serial modular unit
// an item runs five reductions, then, unless the sum needs no slope, one
// inversion and three or four multiplications
// reset clears control only; p returns to 2^64-59 and a to zero
// the result sits in the output register until taken; the next item runs
// meanwhile and waits at its end until the register is free
`default_nettype none
module ecc_affine_point_add_gfp
	import eapa_pkg::*;
#(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_idx,
	input wire logic [63:0] cfg_data,
	eapa_if.sink pin,
	eapa_if.source pout
);
	localparam int unsigned W = COORD_BITS;

	// sequencer states: reduce the five inputs, then the slope and the sum
	typedef enum logic [4:0] {
		S_IDLE, S_RX0, S_RY0, S_RX1, S_RY1, S_RA, S_DEC,
		S_DX, S_DY, S_DINV, S_DLAM,
		S_SQ, S_S3, S_S2, S_SINV, S_SLAM,
		S_L2, S_Y2, S_OUT
	} st_t;

	st_t st_q;
	logic [63:0] prime_q, coeff_q;
	logic [W-1:0] m, x0_q, y0_q, x1_q, y1_q, ca_q, t_q, lam_q;
	logic inf0_q, inf1_q;
	logic go_q;
	op_t op_q;
	logic [W-1:0] opa_q, opb_q;
	logic alu_done;
	logic [W-1:0] alu_res;
	logic out_v_q;
	logic [W-1:0] sx_q, sy_q;
	logic sinf_q;
	// working copy of the sum, moved to the output register at the end
	logic [W-1:0] wx_q, wy_q;
	logic winf_q;

	// a modulus of 0 or 1 behaves as 1
	assign m = (prime_q[W-1:0] < W'(2)) ? W'(1) : prime_q[W-1:0];

	// modular helpers on operands below m
	function automatic logic [W-1:0] addm(logic [W-1:0] x, logic [W-1:0] y);
		logic [W-1:0] room;
		room = m - y;
		return (x >= room) ? x - room : x + y;
	endfunction
	function automatic logic [W-1:0] subm(logic [W-1:0] x, logic [W-1:0] y);
		return (x >= y) ? x - y : m - (y - x);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= PRIME_RST;
			coeff_q <= COEFF_A_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_PRIME: prime_q <= cfg_data;
				CFG_COEFF_A: coeff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	eapa_alu #(.W(W)) u_alu (
		.clk(clk), .arst_n(arst_n), .start(go_q), .op(op_q),
		.opa(opa_q), .opb(opb_q), .m(m), .done(alu_done), .res(alu_res)
	);

	assign pin.ready = (st_q == S_IDLE);
	assign pout.valid = out_v_q;
	assign pout.data.sum_x = 64'(sx_q);
	assign pout.data.sum_y = 64'(sy_q);
	assign pout.data.sum_at_infinity = sinf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			go_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (out_v_q && pout.ready) out_v_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (pin.valid) begin
					x0_q <= pin.data.first_x[W-1:0];
					y0_q <= pin.data.first_y[W-1:0];
					x1_q <= pin.data.second_x[W-1:0];
					y1_q <= pin.data.second_y[W-1:0];
					inf0_q <= pin.data.first_at_infinity;
					inf1_q <= pin.data.second_at_infinity;
					op_q <= OP_RED; opa_q <= pin.data.first_x[W-1:0];
					go_q <= 1'b1; st_q <= S_RX0;
				end
				S_RX0: if (alu_done) begin
					x0_q <= alu_res; opa_q <= y0_q; go_q <= 1'b1; st_q <= S_RY0;
				end
				S_RY0: if (alu_done) begin
					y0_q <= alu_res; opa_q <= x1_q; go_q <= 1'b1; st_q <= S_RX1;
				end
				S_RX1: if (alu_done) begin
					x1_q <= alu_res; opa_q <= y1_q; go_q <= 1'b1; st_q <= S_RY1;
				end
				S_RY1: if (alu_done) begin
					y1_q <= alu_res; opa_q <= coeff_q[W-1:0]; go_q <= 1'b1;
					st_q <= S_RA;
				end
				S_RA: if (alu_done) begin
					ca_q <= alu_res; st_q <= S_DEC;
				end
				S_DEC: begin
					winf_q <= 1'b1; wx_q <= '0; wy_q <= '0;
					if (inf0_q || inf1_q) begin
						if (!(inf0_q && inf1_q)) begin
							winf_q <= 1'b0;
							wx_q <= inf0_q ? x1_q : x0_q;
							wy_q <= inf0_q ? y1_q : y0_q;
						end
						st_q <= S_OUT;
					end else if (x0_q != x1_q) begin
						// chord slope (y0-y1)/(x0-x1)
						t_q <= subm(y0_q, y1_q);
						op_q <= OP_INV; opa_q <= subm(x0_q, x1_q);
						go_q <= 1'b1; st_q <= S_DINV;
					end else if (y0_q != y1_q || y0_q == '0) begin
						st_q <= S_OUT;
					end else begin
						// tangent slope: x^2 first
						op_q <= OP_MUL; opa_q <= x1_q; opb_q <= x1_q;
						go_q <= 1'b1; st_q <= S_SQ;
					end
				end
				S_DINV: if (alu_done) begin
					op_q <= OP_MUL; opa_q <= t_q; opb_q <= alu_res;
					go_q <= 1'b1; st_q <= S_DLAM;
				end
				S_SQ: if (alu_done) begin
					// 3x^2 + a and 2y by modular adds
					t_q <= addm(addm(addm(alu_res, alu_res), alu_res), ca_q);
					op_q <= OP_INV; opa_q <= addm(y1_q, y1_q);
					go_q <= 1'b1; st_q <= S_SINV;
				end
				S_SINV: if (alu_done) begin
					op_q <= OP_MUL; opa_q <= t_q; opb_q <= alu_res;
					go_q <= 1'b1; st_q <= S_DLAM;
				end
				S_DLAM: if (alu_done) begin
					lam_q <= alu_res;
					op_q <= OP_MUL; opa_q <= alu_res; opb_q <= alu_res;
					go_q <= 1'b1; st_q <= S_L2;
				end
				S_L2: if (alu_done) begin
					wx_q <= subm(subm(alu_res, x0_q), x1_q);
					op_q <= OP_MUL; opa_q <= subm(x1_q, subm(subm(alu_res, x0_q), x1_q));
					opb_q <= lam_q; go_q <= 1'b1; st_q <= S_Y2;
				end
				S_Y2: if (alu_done) begin
					wy_q <= subm(alu_res, y1_q); winf_q <= 1'b0; st_q <= S_OUT;
				end
				S_OUT: if (!out_v_q) begin
					sx_q <= wx_q; sy_q <= wy_q; sinf_q <= winf_q;
					out_v_q <= 1'b1; st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pin.ready |-> !go_q) else $error("unit busy while ready");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !pout.ready) |=> out_v_q) else $error("beat dropped");
	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && sinf_q) |-> (sx_q == '0 && sy_q == '0))
		else $error("infinity with coordinates");
endmodule
`default_nettype wire
